// ===== src/cfsc_pkg.sv =====
// Shared types, codes and calendar tables for the clock field setting controller.
// No dependencies; the design files refer to it by scoped names, the testbench files import it.
`default_nettype none

package cfsc_pkg;

    // item kinds
    localparam logic [2:0] KIND_ENTER = 3'd0;
    localparam logic [2:0] KIND_NEXT  = 3'd1;
    localparam logic [2:0] KIND_PLUS  = 3'd2;
    localparam logic [2:0] KIND_MINUS = 3'd3;
    localparam logic [2:0] KIND_TICK  = 3'd4;
    localparam logic [2:0] KIND_OTHER = 3'd5;

    // field positions
    localparam logic [2:0] POS_YEAR         = 3'd0;
    localparam logic [2:0] POS_MONTH        = 3'd1;
    localparam logic [2:0] POS_DAY          = 3'd2;
    localparam logic [2:0] POS_HOUR         = 3'd3;
    localparam logic [2:0] POS_MINUTE       = 3'd4;
    localparam logic [2:0] POS_ALARM_ICON   = 3'd5;
    localparam logic [2:0] POS_ALARM_HOUR   = 3'd6;
    localparam logic [2:0] POS_ALARM_MINUTE = 3'd7;

    // field bounds
    localparam logic [6:0] YEAR_MIN   = 7'd11;
    localparam logic [6:0] YEAR_MAX   = 7'd100;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [7:0] IDLE_MAX   = 8'd255;

    localparam logic [7:0] TIMEOUT_RESET = 8'd20;

    // input word
    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [4:0] load_alarm_hour;
        logic [5:0] load_alarm_minute;
    } in_word_t;

    // result word
    typedef struct packed {
        logic       in_setting;
        logic [2:0] position;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       alarm_on;
        logic       commit;
        logic       timed_out;
    } out_word_t;

    // controller state
    typedef struct packed {
        logic       active;
        logic [2:0] position;
        logic [7:0] idle;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       alarm_on;
    } state_t;

    localparam state_t STATE_RESET = '{
        active:       1'b0,
        position:     POS_YEAR,
        idle:         8'd0,
        year:         7'd11,
        month:        4'd1,
        day:          5'd1,
        hour:         5'd0,
        minute:       6'd0,
        alarm_hour:   5'd0,
        alarm_minute: 6'd0,
        alarm_on:     1'b0
    };

    // days in a month; out-of-range months count 31, february 29 in leap years
    // for years below 128 the leap rule reduces to a multiple of 4 other than 100
    function automatic logic [4:0] month_length(input logic [6:0] y, input logic [3:0] m);
        logic leap;
        logic [4:0] len;
        begin
            leap = (y[1:0] == 2'b00) && (y != YEAR_MAX);
            unique case (m)
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/cfsc_adjust.sv =====
// Plus/minus adjustment of the field selected by the current position.
// Depends on cfsc_pkg for the state type, position codes and month lengths.
`default_nettype none

module cfsc_adjust (
    input  wire cfsc_pkg::state_t cur,
    input  wire                   up,
    output cfsc_pkg::state_t      adj
);

    logic [4:0] len;
    logic [5:0] day_inc;

    assign len     = cfsc_pkg::month_length(cur.year, cur.month);
    assign day_inc = {1'b0, cur.day} + 6'd1;

    // wrap the selected field up or down; the year stops at its minimum going down, the alarm icon stays
    always_comb
    begin
        adj = cur;
        unique case (cur.position)
            cfsc_pkg::POS_YEAR:
            begin
                if (up)
                    adj.year = (cur.year >= cfsc_pkg::YEAR_MAX) ? cfsc_pkg::YEAR_MIN
                                                                : cur.year + 7'd1;
                else
                    adj.year = (cur.year <= cfsc_pkg::YEAR_MIN) ? cfsc_pkg::YEAR_MIN
                                                                : cur.year - 7'd1;
            end
            cfsc_pkg::POS_MONTH:
            begin
                if (up)
                    adj.month = (cur.month >= cfsc_pkg::MONTH_MAX) ? 4'd1 : cur.month + 4'd1;
                else
                    adj.month = (cur.month <= 4'd1 || cur.month > cfsc_pkg::MONTH_MAX)
                              ? cfsc_pkg::MONTH_MAX : cur.month - 4'd1;
            end
            cfsc_pkg::POS_DAY:
            begin
                if (up)
                    adj.day = (day_inc > {1'b0, len}) ? 5'd1 : day_inc[4:0];
                else
                    adj.day = (cur.day <= 5'd1) ? len : cur.day - 5'd1;
            end
            cfsc_pkg::POS_HOUR:
            begin
                if (up)
                    adj.hour = (cur.hour >= cfsc_pkg::HOUR_MAX) ? 5'd0 : cur.hour + 5'd1;
                else
                    adj.hour = (cur.hour == 5'd0 || cur.hour > cfsc_pkg::HOUR_MAX)
                             ? cfsc_pkg::HOUR_MAX : cur.hour - 5'd1;
            end
            cfsc_pkg::POS_MINUTE:
            begin
                if (up)
                    adj.minute = (cur.minute >= cfsc_pkg::MINUTE_MAX) ? 6'd0
                                                                      : cur.minute + 6'd1;
                else
                    adj.minute = (cur.minute == 6'd0 || cur.minute > cfsc_pkg::MINUTE_MAX)
                               ? cfsc_pkg::MINUTE_MAX : cur.minute - 6'd1;
            end
            cfsc_pkg::POS_ALARM_ICON:
            begin
                adj = cur;
            end
            cfsc_pkg::POS_ALARM_HOUR:
            begin
                if (up)
                    adj.alarm_hour = (cur.alarm_hour >= cfsc_pkg::HOUR_MAX) ? 5'd0
                                                                            : cur.alarm_hour + 5'd1;
                else
                    adj.alarm_hour = (cur.alarm_hour == 5'd0
                                      || cur.alarm_hour > cfsc_pkg::HOUR_MAX)
                                   ? cfsc_pkg::HOUR_MAX : cur.alarm_hour - 5'd1;
            end
            cfsc_pkg::POS_ALARM_MINUTE:
            begin
                if (up)
                    adj.alarm_minute = (cur.alarm_minute >= cfsc_pkg::MINUTE_MAX) ? 6'd0
                                     : cur.alarm_minute + 6'd1;
                else
                    adj.alarm_minute = (cur.alarm_minute == 6'd0
                                        || cur.alarm_minute > cfsc_pkg::MINUTE_MAX)
                                     ? cfsc_pkg::MINUTE_MAX : cur.alarm_minute - 6'd1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/cfsc_update.sv =====
// Next-state and result logic for one input word of the setting controller.
// Depends on cfsc_pkg and instantiates cfsc_adjust for plus/minus edits.
`default_nettype none

module cfsc_update (
    input  wire cfsc_pkg::state_t   cur,
    input  wire cfsc_pkg::in_word_t word,
    input  wire [7:0]               timeout,
    output cfsc_pkg::state_t        nxt,
    output cfsc_pkg::out_word_t     result
);

    cfsc_pkg::state_t adj;
    logic             commit;
    logic             timed_out;
    logic [7:0]       idle_inc;

    cfsc_adjust u_adjust (
        .cur (cur),
        .up  (word.kind == cfsc_pkg::KIND_PLUS),
        .adj (adj)
    );

    assign idle_inc = (cur.idle < cfsc_pkg::IDLE_MAX) ? cur.idle + 8'd1 : cur.idle;

    // state transition
    always_comb
    begin
        nxt       = cur;
        commit    = 1'b0;
        timed_out = 1'b0;
        if (word.kind == cfsc_pkg::KIND_ENTER)
        begin
            nxt.year         = word.load_year;
            nxt.month        = word.load_month;
            nxt.day          = word.load_day;
            nxt.hour         = word.load_hour;
            nxt.minute       = word.load_minute;
            nxt.alarm_hour   = word.load_alarm_hour;
            nxt.alarm_minute = word.load_alarm_minute;
            nxt.position     = cfsc_pkg::POS_YEAR;
            nxt.idle         = 8'd0;
            nxt.active       = 1'b1;
        end
        else if (cur.active)
        begin
            if (word.kind != cfsc_pkg::KIND_TICK)
                nxt.idle = 8'd0;
            priority if (word.kind == cfsc_pkg::KIND_NEXT)
            begin
                if (cur.position == cfsc_pkg::POS_ALARM_MINUTE)
                begin
                    nxt.alarm_on = 1'b1;
                    nxt.position = cfsc_pkg::POS_YEAR;
                    nxt.active   = 1'b0;
                    commit       = 1'b1;
                end
                else
                begin
                    nxt.position = cur.position + 3'd1;
                end
            end
            else if (word.kind == cfsc_pkg::KIND_PLUS || word.kind == cfsc_pkg::KIND_MINUS)
            begin
                nxt.year         = adj.year;
                nxt.month        = adj.month;
                nxt.day          = adj.day;
                nxt.hour         = adj.hour;
                nxt.minute       = adj.minute;
                nxt.alarm_hour   = adj.alarm_hour;
                nxt.alarm_minute = adj.alarm_minute;
            end
            else if (word.kind == cfsc_pkg::KIND_TICK)
            begin
                if (idle_inc >= timeout)
                begin
                    nxt.idle   = 8'd0;
                    nxt.active = 1'b0;
                    timed_out  = 1'b1;
                end
                else
                begin
                    nxt.idle = idle_inc;
                end
            end
            else
            begin
                nxt.position = cur.position;
            end
        end
    end

    // result reflects the state after the word
    always_comb
    begin
        result.in_setting   = nxt.active;
        result.position     = nxt.position;
        result.year         = nxt.year;
        result.month        = nxt.month;
        result.day          = nxt.day;
        result.hour         = nxt.hour;
        result.minute       = nxt.minute;
        result.alarm_hour   = nxt.alarm_hour;
        result.alarm_minute = nxt.alarm_minute;
        result.alarm_on     = nxt.alarm_on;
        result.commit       = commit;
        result.timed_out    = timed_out;
    end

endmodule

`default_nettype wire

// ===== src/clock_field_setting_controller.sv =====
// Clock field setting controller: input register, update logic, result register.
// Depends on cfsc_pkg and instantiates cfsc_update.
//
// Usage:
//   in_valid/in_ready/in_data carry one key or tick word (kind plus load values).
//   out_valid/out_ready/out_data carry one result word per input word: the
//   setting state after that word, with commit and timed_out pulses.
//   cfg_wen/cfg_wdata write the timeout in half-second ticks; write it only while idle (not enforced).
// Path: an accepted input word goes through the input register, then the
//   update logic into the result register together with the controller state;
//   out_valid rises when the result word is in the result register.
// Throughput: one word per cycle while out_ready stays high; the update of one
//   word is combinational, so the next word sees the new state.
// Stall: if out_ready is low the result register holds; the input register
//   still takes one more word, after which in_ready drops until the result
//   is taken.
// Reset: both registers empty, display mode, year 11, month 1, day 1, all
//   times zero, alarm off, timeout 20 ticks.
`default_nettype none

module clock_field_setting_controller (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire cfsc_pkg::in_word_t in_data,
    output logic                    out_valid,
    input  wire                     out_ready,
    output cfsc_pkg::out_word_t     out_data,
    input  wire                     cfg_wen,
    input  wire [7:0]               cfg_wdata
);

    logic                in_valid_reg;
    cfsc_pkg::in_word_t  in_word_reg;
    logic                out_valid_reg;
    cfsc_pkg::out_word_t out_word_reg;
    cfsc_pkg::state_t    state_reg;
    cfsc_pkg::state_t    state_next;
    cfsc_pkg::out_word_t out_word_next;
    logic [7:0]          timeout_reg;
    logic                advance;

    // the update stage moves when it holds a word and the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    cfsc_update u_update (
        .cur     (state_reg),
        .word    (in_word_reg),
        .timeout (timeout_reg),
        .nxt     (state_next),
        .result  (out_word_next)
    );

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= cfsc_pkg::TIMEOUT_RESET;
        else if (cfg_wen)
            timeout_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_word_reg <= in_data;
    end

    // controller state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfsc_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

`default_nettype wire

// ===== tb/sv/cfsc_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the clock field setting controller: watches the input,
// result and timeout-register ports, predicts every result word and compares it.
// Depends on cfsc_pkg for the word types and the kind and position codes.

module cfsc_result_checker (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire                     in_ready,
    input  wire cfsc_pkg::in_word_t in_data,
    input  wire                     out_valid,
    input  wire                     out_ready,
    input  wire cfsc_pkg::out_word_t out_data,
    input  wire                     cfg_wen,
    input  wire [7:0]               cfg_wdata,
    output int                      fail_count = 0,
    output int                      pending_words = 0
);
    import cfsc_pkg::*;

    // predicted controller state and timeout register
    state_t      clock_state = STATE_RESET;
    logic [7:0]  timeout_limit = TIMEOUT_RESET;
    out_word_t   expected_words[$];
    int          words_checked = 0;

    task automatic report_mismatch(input string what);
        begin
            fail_count = fail_count + 1;
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        begin
            if (got !== want)
                report_mismatch($sformatf("result word %0d: %s is %0d, expected %0d",
                                          words_checked, name, got, want));
        end
    endtask

    // full gregorian leap rule on the year register value
    function automatic int days_in_month(input int y, input int m);
        begin
            if (m < 1 || m > 12)
                return 31;
            if (m == 2)
                return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        end
    endfunction

    // plus or minus on the selected field
    task automatic adjust_field(input bit up);
        int v;
        int len;
        begin
            case (clock_state.position)
                POS_YEAR:
                begin
                    v = int'(clock_state.year);
                    if (up)
                        v = (v >= 100) ? 11 : v + 1;
                    else
                        v = (v <= 11) ? 11 : v - 1;
                    clock_state.year = 7'(v);
                end
                POS_MONTH:
                begin
                    v = int'(clock_state.month);
                    if (up)
                        v = (v >= 12) ? 1 : v + 1;
                    else
                        v = (v <= 1 || v > 12) ? 12 : v - 1;
                    clock_state.month = 4'(v);
                end
                POS_DAY:
                begin
                    v = int'(clock_state.day);
                    len = days_in_month(int'(clock_state.year), int'(clock_state.month));
                    if (up)
                        v = (v + 1 > len) ? 1 : v + 1;
                    else
                        v = (v <= 1) ? len : v - 1;
                    clock_state.day = 5'(v);
                end
                POS_HOUR:
                begin
                    v = int'(clock_state.hour);
                    if (up)
                        v = (v >= 23) ? 0 : v + 1;
                    else
                        v = (v == 0 || v > 23) ? 23 : v - 1;
                    clock_state.hour = 5'(v);
                end
                POS_MINUTE:
                begin
                    v = int'(clock_state.minute);
                    if (up)
                        v = (v >= 59) ? 0 : v + 1;
                    else
                        v = (v == 0 || v > 59) ? 59 : v - 1;
                    clock_state.minute = 6'(v);
                end
                POS_ALARM_HOUR:
                begin
                    v = int'(clock_state.alarm_hour);
                    if (up)
                        v = (v >= 23) ? 0 : v + 1;
                    else
                        v = (v == 0 || v > 23) ? 23 : v - 1;
                    clock_state.alarm_hour = 5'(v);
                end
                POS_ALARM_MINUTE:
                begin
                    v = int'(clock_state.alarm_minute);
                    if (up)
                        v = (v >= 59) ? 0 : v + 1;
                    else
                        v = (v == 0 || v > 59) ? 59 : v - 1;
                    clock_state.alarm_minute = 6'(v);
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // advance the predicted state by one input word and form its result word
    task automatic predict_word(input in_word_t w, output out_word_t r);
        logic commit_pulse;
        logic timeout_pulse;
        begin
            commit_pulse = 1'b0;
            timeout_pulse = 1'b0;
            if (w.kind == KIND_ENTER)
            begin
                clock_state.year = w.load_year;
                clock_state.month = w.load_month;
                clock_state.day = w.load_day;
                clock_state.hour = w.load_hour;
                clock_state.minute = w.load_minute;
                clock_state.alarm_hour = w.load_alarm_hour;
                clock_state.alarm_minute = w.load_alarm_minute;
                clock_state.position = POS_YEAR;
                clock_state.idle = '0;
                clock_state.active = 1'b1;
            end
            else if (clock_state.active)
            begin
                if (w.kind != KIND_TICK)
                    clock_state.idle = '0;
                case (w.kind)
                    KIND_NEXT:
                    begin
                        if (clock_state.position >= POS_ALARM_MINUTE)
                        begin
                            clock_state.alarm_on = 1'b1;
                            clock_state.position = POS_YEAR;
                            clock_state.active = 1'b0;
                            commit_pulse = 1'b1;
                        end
                        else
                            clock_state.position = clock_state.position + 3'd1;
                    end
                    KIND_PLUS:
                        adjust_field(1'b1);
                    KIND_MINUS:
                        adjust_field(1'b0);
                    KIND_TICK:
                    begin
                        if (clock_state.idle < IDLE_MAX)
                            clock_state.idle = clock_state.idle + 8'd1;
                        if (clock_state.idle >= timeout_limit)
                        begin
                            clock_state.idle = '0;
                            clock_state.active = 1'b0;
                            timeout_pulse = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            r.in_setting = clock_state.active;
            r.position = clock_state.position;
            r.year = clock_state.year;
            r.month = clock_state.month;
            r.day = clock_state.day;
            r.hour = clock_state.hour;
            r.minute = clock_state.minute;
            r.alarm_hour = clock_state.alarm_hour;
            r.alarm_minute = clock_state.alarm_minute;
            r.alarm_on = clock_state.alarm_on;
            r.commit = commit_pulse;
            r.timed_out = timeout_pulse;
        end
    endtask

    task automatic compare_word(input out_word_t got, input out_word_t want);
        begin
            check_field("in_setting", 8'(got.in_setting), 8'(want.in_setting));
            check_field("position", 8'(got.position), 8'(want.position));
            check_field("year", 8'(got.year), 8'(want.year));
            check_field("month", 8'(got.month), 8'(want.month));
            check_field("day", 8'(got.day), 8'(want.day));
            check_field("hour", 8'(got.hour), 8'(want.hour));
            check_field("minute", 8'(got.minute), 8'(want.minute));
            check_field("alarm_hour", 8'(got.alarm_hour), 8'(want.alarm_hour));
            check_field("alarm_minute", 8'(got.alarm_minute), 8'(want.alarm_minute));
            check_field("alarm_on", 8'(got.alarm_on), 8'(want.alarm_on));
            check_field("commit", 8'(got.commit), 8'(want.commit));
            check_field("timed_out", 8'(got.timed_out), 8'(want.timed_out));
        end
    endtask

    // results are compared before the word taken at the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin : watch_ports
        out_word_t predicted;
        if (!rst_n)
        begin
            clock_state = STATE_RESET;
            timeout_limit = TIMEOUT_RESET;
            expected_words.delete();
            pending_words = 0;
        end
        else
        begin
            if (cfg_wen)
                timeout_limit = cfg_wdata;
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("result word %0d arrived with none expected",
                                              words_checked));
                else
                    compare_word(out_data, expected_words.pop_front());
                words_checked = words_checked + 1;
            end
            if (in_valid && in_ready)
            begin
                predict_word(in_data, predicted);
                expected_words.push_back(predicted);
            end
            pending_words = expected_words.size();
        end
    end

endmodule

// ===== tb/sv/clock_field_setting_controller_test.sv =====
`timescale 1ns / 1ps
// Top of the clock field setting controller testbench: clock, reset, stimulus,
// flow control, timeout register writes and the verdict.
// Depends on cfsc_pkg, clock_field_setting_controller and cfsc_result_checker.

module clock_field_setting_controller_test;
    import cfsc_pkg::*;

    // codes outside the defined kinds, handled as other keys
    localparam logic [2:0] KIND_SPARE_LOW  = 3'd6;
    localparam logic [2:0] KIND_SPARE_HIGH = 3'd7;
    localparam int STALL_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_word_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_word_t  out_data;
    logic       cfg_wen = 1'b0;
    logic [7:0] cfg_wdata = '0;

    int fail_count;
    int pending_words;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent = 0;
    int results_taken = 0;
    int quiet_cycles = 0;
    int cur_timeout = int'(TIMEOUT_RESET);

    clock_field_setting_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    cfsc_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver stalls at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog on cycles with work outstanding and no word moving
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            results_taken = results_taken + 1;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else if (in_valid || pending_words != 0)
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("clock_field_setting_controller_test: FAIL");
            $finish;
        end
    end

    function automatic in_word_t make_word(input logic [2:0] kind, input int y, input int mo,
                                           input int d, input int h, input int mi,
                                           input int ah, input int am);
        in_word_t w;
        begin
            w.kind = kind;
            w.load_year = 7'(y);
            w.load_month = 4'(mo);
            w.load_day = 5'(d);
            w.load_hour = 5'(h);
            w.load_minute = 6'(mi);
            w.load_alarm_hour = 5'(ah);
            w.load_alarm_minute = 6'(am);
            return w;
        end
    endfunction

    // load values either in their normal ranges or anywhere in the field width
    function automatic in_word_t random_loads(input logic [2:0] kind, input bit wide);
        begin
            if (wide)
                return make_word(kind, $urandom_range(0, 127), $urandom_range(0, 15),
                                 $urandom_range(0, 31), $urandom_range(0, 31),
                                 $urandom_range(0, 63), $urandom_range(0, 31),
                                 $urandom_range(0, 63));
            return make_word(kind, $urandom_range(11, 100), $urandom_range(1, 12),
                             $urandom_range(1, 31), $urandom_range(0, 23),
                             $urandom_range(0, 59), $urandom_range(0, 23),
                             $urandom_range(0, 59));
        end
    endfunction

    // key word whose load values are ignored by the block
    function automatic in_word_t key(input logic [2:0] kind);
        begin
            return random_loads(kind, 1'b1);
        end
    endfunction

    // one word on the input channel, called at a falling edge
    task automatic send_word(input in_word_t w);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data <= w;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            words_sent = words_sent + 1;
            @(negedge clk);
        end
    endtask

    // hold the sender until every result word has come back
    task automatic drain;
        begin
            in_valid <= 1'b0;
            while (pending_words != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic set_timeout(input int ticks);
        begin
            drain();
            cfg_wen <= 1'b1;
            cfg_wdata <= 8'(ticks);
            @(negedge clk);
            cfg_wen <= 1'b0;
            cur_timeout = ticks;
        end
    endtask

    // field extremes, out-of-range loads, leap day and a full pass to commit
    task automatic run_directed;
        begin
            send_word(key(KIND_TICK));
            send_word(key(KIND_OTHER));
            send_word(key(KIND_NEXT));
            send_word(make_word(KIND_ENTER, 100, 2, 31, 23, 59, 23, 59));
            send_word(key(KIND_PLUS));
            send_word(key(KIND_MINUS));
            // february of a leap year
            send_word(make_word(KIND_ENTER, 96, 2, 28, 0, 0, 0, 0));
            send_word(key(KIND_NEXT));
            send_word(key(KIND_NEXT));
            send_word(key(KIND_PLUS));
            // every field out of range, walked through to commit
            send_word(make_word(KIND_ENTER, 127, 15, 0, 31, 63, 31, 63));
            send_word(key(KIND_PLUS));
            send_word(key(KIND_NEXT));
            send_word(key(KIND_MINUS));
            send_word(key(KIND_NEXT));
            send_word(key(KIND_MINUS));
            send_word(key(KIND_NEXT));
            send_word(key(KIND_PLUS));
            send_word(key(KIND_NEXT));
            send_word(key(KIND_MINUS));
            send_word(key(KIND_NEXT));
            send_word(key(KIND_PLUS));
            send_word(key(KIND_NEXT));
            send_word(key(KIND_MINUS));
            send_word(key(KIND_SPARE_LOW));
            send_word(key(KIND_NEXT));
            send_word(key(KIND_PLUS));
            send_word(key(KIND_SPARE_HIGH));
            send_word(key(KIND_NEXT));
        end
    endtask

    // enter, edits at each position, then commit or a run of ticks (a timeout only if it is at most 30)
    task automatic run_session;
        int n;
        int p;
        int ticks;
        begin
            send_word(random_loads(KIND_ENTER, $urandom_range(0, 9) == 0));
            for (p = 0; p < 8; p++)
            begin
                n = $urandom_range(0, (p == int'(POS_DAY)) ? 6 : 3);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(key($urandom_range(0, 1) ? KIND_TICK : KIND_OTHER));
                    else
                        send_word(key($urandom_range(0, 1) ? KIND_PLUS : KIND_MINUS));
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    ticks = (cur_timeout <= 30) ? cur_timeout : $urandom_range(1, 5);
                    repeat (ticks) send_word(key(KIND_TICK));
                    return;
                end
                send_word(key(KIND_NEXT));
            end
        end
    endtask

    task automatic run_random(input int count);
        int stop;
        int pick;
        begin
            stop = words_sent + count;
            while (words_sent < stop)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    repeat ($urandom_range(1, 4))
                        send_word(random_loads(3'($urandom_range(0, 7)),
                                               $urandom_range(0, 1) == 1));
                else if (pick < 18)
                    drain();
                else
                    run_session();
            end
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // slow receiver, reset timeout, then timeout zero
        send_idle_pct = 19;
        recv_idle_pct = 71;
        run_directed();
        run_random(250);
        set_timeout(0);
        send_word(random_loads(KIND_ENTER, 1'b0));
        send_word(key(KIND_TICK));
        run_random(100);

        // slow sender, longest timeout with a cleared count, then a short one
        send_idle_pct = 71;
        recv_idle_pct = 19;
        set_timeout(255);
        send_word(random_loads(KIND_ENTER, 1'b0));
        repeat (200) send_word(key(KIND_TICK));
        send_word(key(KIND_OTHER));
        repeat (255) send_word(key(KIND_TICK));
        set_timeout(3);
        run_random(200);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timeout(1);
        run_random(100);
        set_timeout(12);
        run_random(100);

        drain();
        repeat (8) @(negedge clk);
        $display("covered %0d input words and %0d result words, timeouts 20, 0, 255, 3, 1, 12",
                 words_sent, results_taken);
        $display("flow control: slow receiver, then slow sender, then back-to-back");
        if (fail_count == 0 && pending_words == 0)
            $display("clock_field_setting_controller_test: PASS");
        else
            $display("clock_field_setting_controller_test: FAIL");
        $finish;
    end

endmodule
